FILE: hw/rtl/cfcw_pkg.sv
// Package for the custom float classify/widen unit: class codes, field widths.
// No dependencies.
`default_nettype none
package cfcw_pkg;
    localparam int FRAC_W = 22;
    localparam int EXP_W  = 9;
    localparam int DB_FRAC_W = 52;
    localparam int DB_EXP_W  = 11;
    localparam int POS_W = 5;

    typedef enum logic [2:0] {
        CLS_NORMAL   = 3'd0,
        CLS_DENORMAL = 3'd1,
        CLS_ZERO     = 3'd2,
        CLS_INF      = 3'd3,
        CLS_NAN      = 3'd4
    } value_class_t;

    localparam logic [DB_EXP_W-1:0] NORM_REBIAS   = 11'd768;
    localparam logic [DB_EXP_W-1:0] DENORM_REBIAS = 11'd747;
    localparam logic [DB_EXP_W-1:0] DB_EXP_ALL    = 11'h7FF;
    localparam logic [EXP_W-1:0]    CF_EXP_MAX    = 9'h1FF;
endpackage
`default_nettype wire

FILE: hw/rtl/custom_float_classify_widen_unit.sv
// Top level: classify a custom 32-bit float and widen it to binary64.
// Depends on cfcw_pkg.
`default_nettype none
// Usage:
//   s_axis: one request per cycle while s_tready is high, s_tdata[31:0] = pattern_word
//   (bit 31 sign, 30..22 exponent with bias 255, 21..0 fraction).
//   m_axis: one result per request, m_tdata[63:0] = double_bits,
//   m_tuser[2:0] = value_class, m_tuser[3] = is_negative.
// Pipeline: three register stages.
//   Stage 1 decodes the fields and classifies.
//   Stage 2 finds the leading one of a denormal fraction.
//   Stage 3 shifts the fraction and assembles the binary64 word.
// An accepted request moves through stages 1, 2 and 3 to m_tvalid; throughput is one
// item per cycle while the receiver does not stall, set by the fully pipelined datapath.
// When the receiver stalls, full stages hold (per-stage enables); a
// request is still taken while any stage is empty, so bubbles collapse.
// Reset (aresetn low, synchronous) clears all valid bits; payload registers
// are not reset.
module custom_float_classify_widen_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] pattern_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] double_bits
    output logic [7:0]       m_tuser    // [2:0] value_class, [3] is_negative
);
    import cfcw_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 en1, en2, en3;
    value_class_t         cls1_reg, cls2_reg, cls3_reg;
    logic                 neg1_reg, neg2_reg, neg3_reg;
    logic [EXP_W-1:0]     exp1_reg;
    logic [FRAC_W-1:0]    frac1_reg, frac2_reg;
    logic [DB_EXP_W-1:0]  dexp2_reg;
    logic [POS_W-1:0]     pos2_reg;
    logic [62:0]          mag3_reg;

    // Advance each stage when its output slot frees up.
    assign en3 = !v3_reg || m_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    // Stage 1: split fields and classify.
    value_class_t cls1_next;
    always_comb begin
        priority if (s_tdata[30:22] == '0 && s_tdata[21:0] == '0) cls1_next = CLS_ZERO;
        else if (s_tdata[30:22] == CF_EXP_MAX)
            cls1_next = (s_tdata[21:0] == '0) ? CLS_INF : CLS_NAN;
        else if (s_tdata[30:22] != '0) cls1_next = CLS_NORMAL;
        else cls1_next = CLS_DENORMAL;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
        if (en1) begin
            cls1_reg  <= cls1_next;
            neg1_reg  <= s_tdata[31];
            exp1_reg  <= s_tdata[30:22];
            frac1_reg <= s_tdata[21:0];
        end
    end

    // Stage 2: rebias, leading-one search.
    logic [POS_W-1:0] pos2_next;
    always_comb begin
        pos2_next = '0;
        for (int i = 1; i < FRAC_W; i++) begin
            if (frac1_reg[i]) pos2_next = POS_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
        if (en2) begin
            cls2_reg  <= cls1_reg;
            neg2_reg  <= neg1_reg;
            frac2_reg <= frac1_reg;
            pos2_reg  <= pos2_next;
            unique case (cls1_reg)
                CLS_NORMAL:   dexp2_reg <= {2'b00, exp1_reg} + NORM_REBIAS;
                CLS_DENORMAL: dexp2_reg <= {6'd0, pos2_next} + DENORM_REBIAS;
                CLS_ZERO:     dexp2_reg <= '0;
                default:      dexp2_reg <= DB_EXP_ALL;
            endcase
        end
    end

    // Stage 3: align fraction and assemble.
    logic [DB_FRAC_W-1:0] dfrac3_next;
    logic [DB_FRAC_W-1:0] wide;
    always_comb begin
        wide = {frac2_reg, 30'd0};
        if (cls2_reg == CLS_DENORMAL) begin
            // Drop the leading one: shift it out the top.
            dfrac3_next = wide << (6'd22 - {1'b0, pos2_reg});
        end else begin
            dfrac3_next = wide;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
        if (en3) begin
            cls3_reg <= cls2_reg;
            neg3_reg <= neg2_reg;
            mag3_reg <= {dexp2_reg, dfrac3_next};
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {neg3_reg, mag3_reg};
    assign m_tuser  = {4'd0, neg3_reg, cls3_reg};

    // Stalled output holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed under stall");
    // Zero results carry only the sign bit.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == CLS_ZERO |-> m_tdata[62:0] == '0)
        else $error("zero result not clean");
    // Infinity and NaN carry an all-ones exponent.
    a_spec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == CLS_INF || m_tuser[2:0] == CLS_NAN)
        |-> m_tdata[62:52] == DB_EXP_ALL)
        else $error("special exponent wrong");
    // Input ready whenever the output side is free.
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("pipeline stalled with free output");
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for custom_float_classify_widen_unit: streams custom float words, predicts
// class, sign and binary64 bits per word and checks every result in order.
// Depends on cfcw_pkg and the unit's RTL.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cfcw_pkg::*;

    typedef struct packed {
        value_class_t       cls;
        logic               neg;
        logic [63:0]        dbl;
    } widened_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] pattern_word
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [63:0] double_bits
    logic [7:0]  m_tuser;   // [2:0] value_class, [3] is_negative

    custom_float_classify_widen_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    logic [31:0] word_q[$];     // words waiting to be sent
    widened_t    widened_q[$];  // predictions waiting for their result
    int          fail_cnt   = 0;
    int          cycle_cnt  = 0;
    bit          no_idle    = 0;  // disable random idling on both sides
    bit          hold_send  = 0;  // sender pause requested by stimulus

    // Predict class, sign and binary64 pattern of one custom float word.
    function automatic widened_t widen_word(logic [31:0] w);
        widened_t r;
        logic [EXP_W-1:0]  e;
        logic [FRAC_W-1:0] f;
        logic [FRAC_W-1:0] rest;
        int p;
        e = w[30:22];
        f = w[21:0];
        r.neg = w[31];
        r.dbl = {w[31], 63'd0};
        if (e == 0 && f == 0) begin
            r.cls = CLS_ZERO;
        end else if (e == CF_EXP_MAX) begin
            r.cls = (f == 0) ? CLS_INF : CLS_NAN;
            r.dbl[62:52] = DB_EXP_ALL;
            r.dbl[51:30] = f;
        end else if (e != 0) begin
            r.cls = CLS_NORMAL;
            r.dbl[62:52] = {2'b00, e} + NORM_REBIAS;
            r.dbl[51:30] = f;
        end else begin
            // denormal: the leading one becomes the hidden bit
            r.cls = CLS_DENORMAL;
            p = 21;
            while (p > 0 && !f[p]) p--;
            rest = f & ((22'd1 << p) - 22'd1);
            r.dbl[62:52] = DENORM_REBIAS + 11'(p);
            r.dbl[51:0] = 52'(rest) << (52 - p);
        end
        return r;
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    // Driver: hold the request until accepted, then advance to the next word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (word_q.size() > 0 && !hold_send &&
                (no_idle || $urandom_range(99) >= 26)) begin
                s_tdata  <= word_q[0];
                s_tvalid <= 1;
                widened_q.push_back(widen_word(word_q.pop_front()));
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        widened_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (widened_q.size() == 0) begin
                $error("unexpected result: tdata=%h tuser=%h", m_tdata, m_tuser);
                fail_cnt++;
            end else begin
                w = widened_q.pop_front();
                if (m_tuser[2:0] !== w.cls) begin
                    $error("value_class: expected %0d, actual %0d", w.cls, m_tuser[2:0]);
                    fail_cnt++;
                end
                if (m_tuser[3] !== w.neg) begin
                    $error("is_negative: expected %0d, actual %0d", w.neg, m_tuser[3]);
                    fail_cnt++;
                end
                if (m_tdata !== w.dbl) begin
                    $error("double_bits: expected %h, actual %h", w.dbl, m_tdata);
                    fail_cnt++;
                end
            end
        end
        m_tready <= !aresetn ? 1'b0 : (no_idle || $urandom_range(99) >= 26);
    end

    // Watchdog: a generous bound over the slowest correct run.
    always @(posedge aclk) begin
        if (cycle_cnt > 200000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] w;
        int k;
        aresetn  = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // Directed: zeros, extremes of each class, every denormal leading-one position.
        word_q.push_back(32'h0000_0000);
        word_q.push_back(32'h8000_0000);
        word_q.push_back(32'h7FC0_0000);
        word_q.push_back(32'hFFC0_0000);
        word_q.push_back(32'h7FC0_0001);
        word_q.push_back(32'hFFFF_FFFF);
        word_q.push_back(32'h0040_0000);
        word_q.push_back(32'h7FBF_FFFF);
        word_q.push_back(32'hBFC0_0000);
        word_q.push_back(32'h0000_0001);
        word_q.push_back(32'h803F_FFFF);
        for (k = 0; k < 22; k++) word_q.push_back((32'd1 << k) | ($urandom & ((1 << k) - 1)));

        // Random: mostly uniform words, with classes that a uniform draw rarely hits.
        for (k = 0; k < 1350; k++) begin
            w = $urandom;
            case ($urandom_range(7))
                0: w[30:22] = 9'd0;
                1: w[30:22] = CF_EXP_MAX;
                2: w[30:0] = $urandom_range(1) ? {9'd0, 22'd0} : {CF_EXP_MAX, 22'd0};
                default: ;
            endcase
            // Hold the sender once until the pipeline drains.
            if (k == 500) begin
                wait (word_q.size() == 0);
                hold_send = 1;
                wait (widened_q.size() == 0);
                @(posedge aclk);
                hold_send = 0;
            end
            // Run a long stretch with no idling on either side.
            if (k == 700) begin
                wait (word_q.size() == 0);
                no_idle = 1;
            end
            if (k == 1000) begin
                wait (word_q.size() == 0);
                no_idle = 0;
            end
            word_q.push_back(w);
        end

        wait (word_q.size() == 0 && !s_tvalid);
        wait (widened_q.size() == 0);
        repeat (10) @(posedge aclk);
        if (fail_cnt == 0 && widened_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
